// ===== hw/rtl/v3n_pkg.sv =====
// Shared types and constants for the vector3_normalise pipeline.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package v3n_pkg;

	localparam int COMP_W      = 32;
	localparam int SUM_W       = 64;
	localparam int SQRT_STAGES = 8;
	localparam int SQRT_STEPS  = 4;
	localparam int DIV_STAGES  = 8;
	localparam int DIV_STEPS   = 4;
	localparam logic [COMP_W-1:0] OUT_ONE = 32'h4000_0000;

	typedef struct packed {
		logic signed [COMP_W-1:0] vec_x;
		logic signed [COMP_W-1:0] vec_y;
		logic signed [COMP_W-1:0] vec_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] unit_x;
		logic signed [COMP_W-1:0] unit_y;
		logic signed [COMP_W-1:0] unit_z;
		logic                     was_zero;
	} vec_out_t;

	// Values that ride along with an item through the pipeline.
	typedef struct packed {
		logic [2:0][COMP_W-1:0] mag;
		logic [2:0]             neg;
		logic                   zero;
	} side_t;

	typedef struct packed {
		logic [33:0]        rem;
		logic [31:0]        root;
		logic [SUM_W-1:0]   n;
	} sqrt_st_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0][31:0] n;
		logic [2:0][31:0] q;
		logic [31:0]      root;
	} div_st_t;

endpackage

// ===== hw/rtl/v3n_front.sv =====
// Front stages: magnitudes, squares, squared length, zero test, normalizing shift.
// Depends on v3n_pkg.
`timescale 1ns / 1ps

module v3n_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid_in,
	input  v3n_pkg::vec_in_t              item_in,
	input  logic [31:0]                   thr,
	output logic                          valid_out,
	output v3n_pkg::side_t                side_out,
	output logic [v3n_pkg::SUM_W-1:0]     norm_out
);

	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [2:0][63:0] sq_s2;
	logic [2:0]       neg_s2;
	logic [2:0][31:0] mag_s2;
	logic [63:0]      sum_s3;
	logic             zero_s3;
	logic [2:0]       neg_s3;
	logic [2:0][31:0] mag_s3;
	logic [63:0]      sum_s4;
	logic [3:0]       nz_s4;
	logic [3:0][3:0]  clz_s4;
	logic             zero_s4;
	logic [2:0]       neg_s4;
	logic [2:0][31:0] mag_s4;
	logic [4:0]       vld_q;

	logic [2:0][31:0] comp;
	logic [63:0]      sum_c;
	logic [5:0]       lz_c;
	logic [4:0]       sh_c;

	function automatic logic [3:0] lz16(input logic [15:0] w);
		logic [3:0] r;
		logic       hit;
		r = 4'd0;
		hit = 1'b0;
		for (int b = 15; b >= 0; b--) begin
			if (!hit && w[b]) begin
				hit = 1'b1;
				r = 4'(15 - b);
			end
		end
		return r;
	endfunction

	assign comp = {item_in.vec_x, item_in.vec_y, item_in.vec_z};
	assign sum_c = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_comb begin
		lz_c = 6'd0;
		priority if (nz_s4[3]) lz_c = {2'd0, clz_s4[3]};
		else if (nz_s4[2]) lz_c = {2'd1, clz_s4[2]};
		else if (nz_s4[1]) lz_c = {2'd2, clz_s4[1]};
		else if (nz_s4[0]) lz_c = {2'd3, clz_s4[0]};
		else lz_c = 6'd0;
		sh_c = lz_c[5:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[3:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[2-i][31];
				mag_s1[i] <= comp[2-i][31] ? 32'(-comp[2-i]) : comp[2-i];
				sq_s2[i]  <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
			end
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			sum_s3  <= sum_c;
			zero_s3 <= sum_c <= {32'd0, thr};
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			sum_s4  <= sum_s3;
			for (int c = 0; c < 4; c++) begin
				nz_s4[c]  <= |sum_s3[c*16 +: 16];
				clz_s4[c] <= lz16(sum_s3[c*16 +: 16]);
			end
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			mag_s4  <= mag_s3;
			norm_out <= sum_s4 << {sh_c, 1'b0};
			for (int i = 0; i < 3; i++) begin
				side_out.mag[i] <= mag_s4[i] << sh_c;
			end
			side_out.neg  <= neg_s4;
			side_out.zero <= zero_s4;
		end
	end

	assign valid_out = vld_q[4];

endmodule

// ===== hw/rtl/v3n_sqrt.sv =====
// Pipelined digit-by-digit integer square root of the normalized squared length.
// Depends on v3n_pkg.
`timescale 1ns / 1ps

module v3n_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      valid_in,
	input  v3n_pkg::side_t            side_in,
	input  logic [v3n_pkg::SUM_W-1:0] norm_in,
	output logic                      valid_out,
	output v3n_pkg::side_t            side_out,
	output logic [31:0]               root_out
);

	localparam int N = v3n_pkg::SQRT_STAGES;

	v3n_pkg::sqrt_st_t st_s   [N];
	v3n_pkg::side_t    side_s [N];
	logic [N-1:0]      vld_s;
	v3n_pkg::sqrt_st_t init;

	function automatic v3n_pkg::sqrt_st_t sqrt_steps(input v3n_pkg::sqrt_st_t a);
		v3n_pkg::sqrt_st_t r;
		logic [35:0]       t;
		logic [33:0]       tr;
		r = a;
		for (int j = 0; j < v3n_pkg::SQRT_STEPS; j++) begin
			t  = {r.rem, r.n[63:62]};
			tr = {r.root, 2'b01};
			if (t >= {2'b00, tr}) begin
				r.rem  = 34'(t - {2'b00, tr});
				r.root = {r.root[30:0], 1'b1};
			end else begin
				r.rem  = t[33:0];
				r.root = {r.root[30:0], 1'b0};
			end
			r.n = {r.n[61:0], 2'b00};
		end
		return r;
	endfunction

	always_comb begin
		init.rem  = '0;
		init.root = '0;
		init.n    = norm_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-2:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]   <= sqrt_steps(init);
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				st_s[k]   <= sqrt_steps(st_s[k-1]);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign valid_out = vld_s[N-1];
	assign side_out  = side_s[N-1];
	assign root_out  = st_s[N-1].root;

endmodule

// ===== hw/rtl/v3n_div.sv =====
// Rounded restoring division of each scaled component by the root, three lanes.
// Depends on v3n_pkg.
`timescale 1ns / 1ps

module v3n_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  valid_in,
	input  v3n_pkg::side_t        side_in,
	input  logic [31:0]           root_in,
	output logic                  valid_out,
	output v3n_pkg::side_t        side_out,
	output logic [2:0][31:0]      quot_out
);

	localparam int N = v3n_pkg::DIV_STAGES;

	v3n_pkg::div_st_t prep_s0;
	v3n_pkg::side_t   side_s0;
	v3n_pkg::div_st_t st_s   [N];
	v3n_pkg::side_t   side_s [N];
	logic [N:0]       vld_s;
	v3n_pkg::div_st_t prep_c;
	logic [2:0][62:0] num_c;

	function automatic v3n_pkg::div_st_t div_steps(input v3n_pkg::div_st_t a);
		v3n_pkg::div_st_t r;
		logic [32:0]      t;
		r = a;
		for (int j = 0; j < v3n_pkg::DIV_STEPS; j++) begin
			for (int l = 0; l < 3; l++) begin
				t = {r.rem[l], r.n[l][31]};
				if (t >= {1'b0, r.root}) begin
					r.rem[l] = 32'(t - {1'b0, r.root});
					r.q[l]   = {r.q[l][30:0], 1'b1};
				end else begin
					r.rem[l] = t[31:0];
					r.q[l]   = {r.q[l][30:0], 1'b0};
				end
				r.n[l] = {r.n[l][30:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Fold the half-divisor rounding term into the dividend.
	always_comb begin
		prep_c.root = root_in;
		for (int l = 0; l < 3; l++) begin
			num_c[l]      = {1'b0, side_in.mag[l], 30'd0} + {32'd0, root_in[31:1]};
			prep_c.rem[l] = {1'b0, num_c[l][62:32]};
			prep_c.n[l]   = num_c[l][31:0];
			prep_c.q[l]   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-1:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s0   <= prep_c;
			side_s0   <= side_in;
			st_s[0]   <= div_steps(prep_s0);
			side_s[0] <= side_s0;
			for (int k = 1; k < N; k++) begin
				st_s[k]   <= div_steps(st_s[k-1]);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign valid_out = vld_s[N];
	assign side_out  = side_s[N-1];
	assign quot_out  = st_s[N-1].q;

endmodule

// ===== hw/rtl/vector3_normalise.sv =====
// Top level of the 3D vector normalizer: handshake, threshold register, output stage.
// Depends on v3n_pkg, v3n_front, v3n_sqrt and v3n_div.
`timescale 1ns / 1ps

// Usage:
// An item on vec (three signed Q15.16 components) is taken at a clock edge where
// vec_valid is high and vec_stall is low. Its result appears on unit (three signed
// Q1.30 components and was_zero) with unit_valid high. One item enters per cycle
// while vec_stall is low: five front stages (magnitudes, 32x32 squares, sum and
// zero test, two-stage shift search), eight square-root stages of four root bits
// each, nine division stages (rounding add, then four quotient bits per stage)
// and the output register.
// The threshold is written through cfg_we/cfg_data and is compared against the
// 64-bit squared length zero-extended; write it only while the block is empty.
// Reset (arst_n low) empties the pipeline and clears the threshold to zero.
// While unit_stall holds a waiting result, the whole pipeline freezes and
// vec_stall is raised; nothing is dropped or repeated.
module vector3_normalise (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_stall,
	input  v3n_pkg::vec_in_t   vec,
	output logic               unit_valid,
	input  logic               unit_stall,
	output v3n_pkg::vec_out_t  unit,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data
);

	logic              adv;
	logic [31:0]       thr_q;
	logic              f_valid, r_valid, d_valid;
	v3n_pkg::side_t    f_side, r_side, d_side;
	logic [63:0]       f_norm;
	logic [31:0]       r_root;
	logic [2:0][31:0]  d_quot;
	logic [2:0][31:0]  sat_c;
	logic [2:0][31:0]  res_c;
	logic              out_valid_q;
	v3n_pkg::vec_out_t out_q;

	// Hold everything while a finished result is stalled.
	assign adv       = !(out_valid_q && unit_stall);
	assign vec_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	v3n_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.valid_in(vec_valid), .item_in(vec), .thr(thr_q),
		.valid_out(f_valid), .side_out(f_side), .norm_out(f_norm)
	);

	v3n_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.valid_in(f_valid), .side_in(f_side), .norm_in(f_norm),
		.valid_out(r_valid), .side_out(r_side), .root_out(r_root)
	);

	v3n_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.valid_in(r_valid), .side_in(r_side), .root_in(r_root),
		.valid_out(d_valid), .side_out(d_side), .quot_out(d_quot)
	);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sat_c[l] = (d_quot[l] > v3n_pkg::OUT_ONE) ? v3n_pkg::OUT_ONE : d_quot[l];
			if (d_side.zero) begin
				res_c[l] = '0;
			end else begin
				res_c[l] = d_side.neg[l] ? 32'(-sat_c[l]) : sat_c[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.unit_x   <= res_c[0];
			out_q.unit_y   <= res_c[1];
			out_q.unit_z   <= res_c[2];
			out_q.was_zero <= d_side.zero;
		end
	end

	assign unit_valid = out_valid_q;
	assign unit       = out_q;

	a_zero_means_null: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit.was_zero |->
			unit.unit_x == 0 && unit.unit_y == 0 && unit.unit_z == 0)
		else $error("zero flag with non-null vector");

	a_x_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid |-> unit.unit_x <= 32'sh4000_0000 && unit.unit_x >= -32'sh4000_0000)
		else $error("unit_x outside plus or minus one");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_stall |-> vec_stall)
		else $error("input taken while result stalled");

	a_thr_written: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> thr_q == $past(cfg_data))
		else $error("threshold write lost");

endmodule

// ===== dv/v3n_checker.sv =====
// Checker for vector3_normalise: watches the vec and unit channels and the threshold port.
// Predicts each unit vector from accepted vec items and compares; depends on v3n_pkg.
`timescale 1ns / 1ps

module v3n_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vec_valid,
	input  logic              vec_stall,
	input  v3n_pkg::vec_in_t  vec,
	input  logic              unit_valid,
	input  logic              unit_stall,
	input  v3n_pkg::vec_out_t unit,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	output int                fail_count,
	output int                pending
);

	logic [31:0]       threshold;
	v3n_pkg::vec_out_t expected_units[$];

	function automatic logic [63:0] root64(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic v3n_pkg::vec_out_t normalize(input v3n_pkg::vec_in_t v);
		logic [31:0]       comp[3];
		logic [63:0]       mag[3];
		logic              neg[3];
		logic [63:0]       len_sq;
		logic [63:0]       norm;
		logic [63:0]       root;
		logic [63:0]       q;
		logic [31:0]       res[3];
		int                shift;
		v3n_pkg::vec_out_t r;
		comp[0] = v.vec_x;
		comp[1] = v.vec_y;
		comp[2] = v.vec_z;
		len_sq = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = comp[i][31];
			mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, comp[i]}) : {32'd0, comp[i]};
			len_sq = len_sq + mag[i] * mag[i];
		end
		r = '0;
		if (len_sq <= {32'd0, threshold}) begin
			r.was_zero = 1'b1;
			return r;
		end
		norm = len_sq;
		shift = 0;
		while (norm < (64'd1 << 62)) begin
			norm = norm << 2;
			shift++;
		end
		root = root64(norm);
		for (int i = 0; i < 3; i++) begin
			q = (((mag[i] << shift) << 30) + (root >> 1)) / root;
			if (q > 64'h4000_0000)
				q = 64'h4000_0000;
			res[i] = neg[i] ? (32'd0 - q[31:0]) : q[31:0];
		end
		r.unit_x = res[0];
		r.unit_y = res[1];
		r.unit_z = res[2];
		return r;
	endfunction

	assign pending = expected_units.size();

	always @(posedge clk or negedge arst_n) begin
		v3n_pkg::vec_out_t e;
		int                errs;
		errs = 0;
		if (!arst_n) begin
			threshold <= '0;
			fail_count <= 0;
			expected_units.delete();
		end else begin
			if (cfg_we)
				threshold <= cfg_data;
			if (vec_valid && !vec_stall)
				expected_units.push_back(normalize(vec));
			if (unit_valid && !unit_stall) begin
				if (expected_units.size() == 0) begin
					$error("unit item with nothing expected");
					errs++;
				end else begin
					e = expected_units.pop_front();
					if (unit.unit_x !== e.unit_x) begin
						$error("unit_x expected %h got %h", e.unit_x, unit.unit_x);
						errs++;
					end
					if (unit.unit_y !== e.unit_y) begin
						$error("unit_y expected %h got %h", e.unit_y, unit.unit_y);
						errs++;
					end
					if (unit.unit_z !== e.unit_z) begin
						$error("unit_z expected %h got %h", e.unit_z, unit.unit_z);
						errs++;
					end
					if (unit.was_zero !== e.was_zero) begin
						$error("was_zero expected %b got %b", e.was_zero, unit.was_zero);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== dv/tb_vector3_normalise.sv =====
// Testbench top for vector3_normalise: clock, reset, stimulus, receiver stalls, verdict.
// Depends on v3n_pkg, vector3_normalise and v3n_checker.
`timescale 1ns / 1ps

module tb_vector3_normalise;

	logic              clk;
	logic              arst_n;
	logic              vec_valid;
	logic              vec_stall;
	v3n_pkg::vec_in_t  vec;
	logic              unit_valid;
	logic              unit_stall;
	v3n_pkg::vec_out_t unit;
	logic              cfg_we;
	logic [31:0]       cfg_data;
	int                fail_count;
	int                pending;
	logic              hold_long;
	logic              hold_done;

	vector3_normalise dut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.unit_valid(unit_valid), .unit_stall(unit_stall), .unit(unit),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	v3n_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.unit_valid(unit_valid), .unit_stall(unit_stall), .unit(unit),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("vector3_normalise test failed");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mostly small and moderate vectors, with some full-scale and edge components.
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 7))
		0: return $urandom;
		1: return 32'h8000_0000;
		2: return 32'h7fff_ffff;
		3: return $urandom_range(0, 15) - 8;
		4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
		default: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom)} << $urandom_range(0, 23);
		endcase
	endfunction

	// Drive at the falling edge; the block samples at the rising edge.
	task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		int g;
		g = gap_len();
		repeat (g) begin
			vec_valid = 1'b0;
			@(negedge clk);
		end
		vec_valid = 1'b1;
		vec.vec_x = x;
		vec.vec_y = y;
		vec.vec_z = z;
		@(posedge clk);
		while (vec_stall)
			@(posedge clk);
		@(negedge clk);
		vec_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		// cover the pipeline depth before touching the threshold
		repeat (30) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		unit_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long && !hold_done) begin
				unit_stall <= 1'b1;
				repeat (80) @(negedge clk);
				unit_stall <= 1'b0;
				hold_done = 1'b1;
			end else if ($urandom_range(0, 99) < 70) begin
				unit_stall <= 1'b0;
			end else begin
				unit_stall <= 1'b1;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	initial begin
		logic [31:0] thresholds[6];
		thresholds = '{32'd0, 32'hffff_ffff, 32'd1, 32'h0001_0000, 32'h8000_0000, 32'd100};
		arst_n = 1'b0;
		vec_valid = 1'b0;
		vec = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		hold_long = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero, extremes, most negative, axis vectors, rounding near one
		send_vec(0, 0, 0);
		send_vec(32'h8000_0000, 0, 0);
		send_vec(0, 32'h8000_0000, 0);
		send_vec(0, 0, 32'h8000_0000);
		send_vec(32'h7fff_ffff, 0, 0);
		send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_vec(1, 0, 0);
		send_vec(32'hffff_ffff, 0, 0);
		send_vec(1, 1, 1);
		send_vec(32'hffff_ffff, 1, 32'hffff_ffff);
		send_vec(3, 4, 0);
		send_vec(32'h0001_0000, 32'h0001_0000, 0);
		send_vec(32'h7fff_ffff, 1, 0);
		send_vec(32'h8000_0000, 32'h7fff_ffff, 1);
		send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
		drain();
		write_threshold(32'hffff_ffff);
		send_vec(32'h0000_ffff, 0, 0);
		send_vec(32'h0001_0000, 0, 0);
		send_vec(32'h0000_b504, 32'h0000_b504, 0);
		send_vec(32'h8000_0000, 0, 0);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_threshold(thresholds[ph]);
			for (int n = 0; n < 320; n++) begin
				if (ph == 2 && n == 100)
					hold_long = 1'b1;
				if (ph == 4 && n == 150)
					drain();
				send_vec(rand_comp(), rand_comp(), rand_comp());
			end
		end

		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("vector3_normalise test passed");
		else
			$display("vector3_normalise test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_front.sv
hw/rtl/v3n_sqrt.sv
hw/rtl/v3n_div.sv
hw/rtl/vector3_normalise.sv
dv/v3n_checker.sv
dv/tb_vector3_normalise.sv
